@@ sv/servo_ramp_with_angle_map_top_macros.svh @@
// assertion macros for the servo ramp block
// used by servo_ramp_with_angle_map_top; no other dependencies
`ifndef SERVO_RAMP_WITH_ANGLE_MAP_TOP_MACROS_SVH
`define SERVO_RAMP_WITH_ANGLE_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRAWM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srawm: implication check failed");
// next-cycle implication
`define SRAWM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srawm: next-cycle check failed");
`else
`define SRAWM_ASSERT_IMP(name, clk, rst, ante, cons)
`define SRAWM_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

@@ sv/srawm_pkg.sv @@
// shared types, constants and calibration table for the servo ramp block
// no dependencies; used by servo_ramp_with_angle_map_top
`default_nettype none

package srawm_pkg;

  localparam int JOINTS_DEF    = 16;
  localparam int MAX_STEPS_DEF = 64;

  localparam int JOINT_BITS = 4;
  localparam int PULSE_BITS = 12;
  localparam int STEP_BITS  = 7;
  localparam int ANGLE_BITS = 16;

  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 40;

  // calibration arithmetic
  localparam int NUM_BITS   = 9;
  localparam int BASE_BITS  = 18;
  localparam int BOT_BITS   = 30;
  localparam int DIFF_BITS  = PULSE_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + NUM_BITS;
  localparam int MAG_BITS   = PROD_BITS - 1;
  localparam int RAD_K_BITS = 25;
  localparam int SCALE_BITS = MAG_BITS + RAD_K_BITS;

  // pi * 4096 / 180 scaled against 390625 * den
  localparam logic [RAD_K_BITS-1:0] RAD_K = 25'd27925268;

  // shared restoring divider
  localparam int DIV_BITS = 48;
  localparam int QUO_BITS = 18;
  localparam int CNT_BITS = 5;
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(QUO_BITS - 1);

  localparam logic [QUO_BITS-1:0]   Q_NEG_LIM = 18'd32768;
  localparam logic [QUO_BITS-1:0]   Q_POS_LIM = 18'd32767;
  localparam logic [ANGLE_BITS-1:0] ANGLE_MIN = 16'h8000;
  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 16'h7FFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SETUP,
    ST_STEP,
    ST_MUL,
    ST_ABS,
    ST_SCALE,
    ST_LOAD,
    ST_ANGLE,
    ST_OUT
  } state_t;

  typedef enum logic {
    DK_RAMP,
    DK_ANGLE
  } div_kind_t;

  // per-joint calibration: base terms are base*den, bot terms 390625*den
  typedef struct packed {
    logic [PULSE_BITS-1:0]        center;
    logic signed [NUM_BITS-1:0]   lo_num;
    logic signed [NUM_BITS-1:0]   hi_num;
    logic signed [BASE_BITS-1:0]  lo_base;
    logic signed [BASE_BITS-1:0]  hi_base;
    logic [BOT_BITS-1:0]          lo_bot;
    logic [BOT_BITS-1:0]          hi_bot;
  } calib_t;

  function automatic calib_t calib_f(input logic [JOINT_BITS-1:0] j);
    calib_t c;
    case (j)
      4'd0:  c = '{12'd1700, -9'sd120,  -9'sd60,  -18'sd99900,  -18'sd36900,
                  30'd433593750, 30'd160156250};
      4'd1:  c = '{12'd1269, -9'sd30,   -9'sd120, -18'sd28710,  -18'sd101790,
                  30'd124609375, 30'd441796875};
      4'd2:  c = '{12'd1625, -9'sd85,   -9'sd60,  18'sd0,       18'sd0,
                  30'd369140625, 30'd244140625};
      4'd3:  c = '{12'd1545, -9'sd90,   -9'sd90,  18'sd86850,   18'sd72450,
                  30'd376953125, 30'd314453125};
      4'd4:  c = '{12'd1710, -9'sd90,   -9'sd129, 18'sd0,       18'sd0,
                  30'd121093750, 30'd156250000};
      4'd5:  c = '{12'd2000, 9'sd105,   9'sd105,  -18'sd29700,  -18'sd31500,
                  30'd128906250, 30'd136718750};
      4'd6:  c = '{12'd2300, 9'sd110,   9'sd5,    -18'sd75600,  -18'sd9000,
                  30'd328125000, 30'd39062500};
      4'd7:  c = '{12'd760,  9'sd20,    9'sd192,  18'sd0,       18'sd0,
                  30'd91796875,  30'd660156250};
      4'd8:  c = '{12'd1290, -9'sd60,   -9'sd120, -18'sd29700,  -18'sd98100,
                  30'd128906250, 30'd425781250};
      4'd9:  c = '{12'd1720, -9'sd120,  -9'sd30,  -18'sd103950, -18'sd26550,
                  30'd451171875, 30'd115234375};
      // upper segment span kept as in the calibration data
      4'd10: c = '{12'd1570, 9'sd60,    9'sd85,   18'sd0,       18'sd0,
                  30'd359375000, 30'd244140625};
      4'd11: c = '{12'd1520, 9'sd90,    9'sd90,   18'sd84600,   18'sd81900,
                  30'd367187500, 30'd355468750};
      4'd12: c = '{12'd1940, 9'sd129,   9'sd90,   18'sd0,       18'sd0,
                  30'd167968750, 30'd123046875};
      4'd13: c = '{12'd2010, -9'sd105,  -9'sd105, -18'sd30600,  -18'sd30600,
                  30'd132812500, 30'd132812500};
      4'd14: c = '{12'd1240, -9'sd5,    -9'sd110, -18'sd6300,   -18'sd69750,
                  30'd27343750,  30'd302734375};
      4'd15: c = '{12'd2200, -9'sd192,  -9'sd20,  18'sd0,       18'sd0,
                  30'd640625000, 30'd97656250};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [PULSE_BITS-1:0] center_f(input logic [JOINT_BITS-1:0] j);
    calib_t c;
    c = calib_f(j);
    return c.center;
  endfunction

endpackage

`default_nettype wire

@@ sv/servo_ramp_with_angle_map_top.sv @@
// servo move ramp generator with per-joint piecewise-linear angle mapping
// depends on srawm_pkg and servo_ramp_with_angle_map_top_macros.svh
`default_nettype none

// A move request names a joint, a target pulse and a step count (counts above
// MAX_STEPS are clipped to MAX_STEPS). The block holds the present pulse of
// every joint, reset to that joint's calibration centre, and for step i of n it
// emits start + floor((target - start) * i / n), so the last step lands on the
// target, which then becomes the joint's stored pulse. Each emitted pulse is
// mapped through the joint's two-segment calibration to degrees, converted to
// radians and given as signed Q3.12, rounded to nearest (ties away from zero)
// and saturated. A request for a joint at or above JOINTS, with zero steps or
// with the target equal to the stored pulse produces no transfers at all.
// Timing: the block takes one request at a time and is not ready while a move
// is in progress. One 48-bit restoring divider, shared between the ramp slope
// and the angle scaling, produces one quotient bit per cycle; besides the
// division, each step passes through the position update, calibration multiply,
// magnitude, scaling multiply, divider load, angle saturation and output transfer.
// Each output transfer waits for m_tready.
`include "servo_ramp_with_angle_map_top_macros.svh"

module servo_ramp_with_angle_map_top
  import srawm_pkg::*;
#(
  parameter int JOINTS    = JOINTS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // request stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // joint[3:0], target_pulse[15:4], steps[22:16], pad
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // joint_out[3:0], step_index[10:4], pulse[22:11],
                                               // angle[38:23], pad
  output logic                      m_tlast
);

  localparam int JIDX_BITS = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JOINT_BITS:0] JOINT_LIMIT = (JOINT_BITS + 1)'(JOINTS);
  localparam logic [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(MAX_STEPS);

  // sequencer
  state_t    state, state_next;
  div_kind_t div_kind;
  logic [CNT_BITS-1:0] div_cnt;

  // per-joint stored position
  logic [PULSE_BITS-1:0] cur_pulse [JOINTS];

  // latched request
  logic [JOINT_BITS-1:0] joint_q;
  logic [PULSE_BITS-1:0] target_q;
  logic [STEP_BITS-1:0]  steps_q;

  // ramp state: position, step index, slope quotient and remainder accumulator
  logic [PULSE_BITS-1:0]       pos;
  logic [STEP_BITS-1:0]        step_counter;
  logic [STEP_BITS-1:0]        acc;
  logic [STEP_BITS-1:0]        dr;
  logic signed [DIFF_BITS-1:0] dq;
  logic                        diff_neg;

  // angle datapath
  logic                        seg_hi;
  logic                        ang_neg;
  logic signed [PROD_BITS-1:0] prod;
  logic [MAG_BITS-1:0]         mag;
  logic [SCALE_BITS-1:0]       scaled;
  logic [ANGLE_BITS-1:0]       out_angle;

  // shared divider
  logic [DIV_BITS-1:0] rem, dvs;
  logic [QUO_BITS-1:0] quo;
  logic                div_ge;

  // ---------------------------------------------------------------- comb
  logic [STEP_BITS-1:0]        s_steps, steps_sat;
  calib_t                      cal;
  logic                        joint_ok, no_move, step_last;
  logic [PULSE_BITS-1:0]       start_pulse;
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        diff_mag;
  logic [PULSE_BITS-1:0]       qm;
  logic [STEP_BITS-1:0]        rm;
  logic signed [DIFF_BITS-1:0] dq_calc;
  logic [STEP_BITS-1:0]        dr_calc;
  logic [STEP_BITS:0]          acc_sum;
  logic                        carry;
  logic [STEP_BITS-1:0]        acc_new;
  logic [DIFF_BITS:0]          pos_sum;
  logic signed [DIFF_BITS-1:0] d_cal;
  logic signed [NUM_BITS-1:0]  num_sel;
  logic signed [PROD_BITS-1:0] prod_calc;
  logic signed [BASE_BITS-1:0] base_sel;
  logic signed [PROD_BITS-1:0] n_deg;
  logic [PROD_BITS-1:0]        n_abs;
  logic [BOT_BITS-1:0]         bot_sel;
  logic [ANGLE_BITS-1:0]       angle_calc;

  assign s_steps   = s_tdata[22:16];
  assign steps_sat = (s_steps > STEP_MAX) ? STEP_MAX : s_steps;

  assign cal         = calib_f(joint_q);
  assign joint_ok    = ({1'b0, joint_q} < JOINT_LIMIT);
  assign start_pulse = cur_pulse[joint_q[JIDX_BITS-1:0]];
  assign diff        = $signed({1'b0, target_q}) - $signed({1'b0, start_pulse});
  assign diff_mag    = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
  assign no_move     = !joint_ok || (steps_q == '0) || (target_q == start_pulse);
  assign step_last   = (step_counter == steps_q);

  // floor division from the magnitude quotient and remainder
  assign qm      = quo[PULSE_BITS-1:0];
  assign rm      = rem[STEP_BITS-1:0];
  assign dq_calc = !diff_neg ? $signed({1'b0, qm}) :
                   (rm == '0) ? -$signed({1'b0, qm}) :
                                -$signed({1'b0, qm}) - DIFF_BITS'(1);
  assign dr_calc = (diff_neg && (rm != '0)) ? STEP_BITS'(steps_q - rm) : rm;

  // one ramp step: carry the remainder, move the position
  assign acc_sum = {1'b0, acc} + {1'b0, dr};
  assign carry   = (acc_sum >= {1'b0, steps_q});
  assign acc_new = carry ? STEP_BITS'(acc_sum - {1'b0, steps_q}) : acc_sum[STEP_BITS-1:0];
  assign pos_sum = {2'b00, pos} + {dq[DIFF_BITS-1], dq} + {{DIFF_BITS{1'b0}}, carry};

  // calibration segment and degree numerator
  assign d_cal     = $signed({1'b0, pos}) - $signed({1'b0, cal.center});
  assign num_sel   = d_cal[DIFF_BITS-1] ? cal.lo_num : cal.hi_num;
  assign prod_calc = $signed({{NUM_BITS{d_cal[DIFF_BITS-1]}}, d_cal})
                   * $signed({{DIFF_BITS{num_sel[NUM_BITS-1]}}, num_sel});
  assign base_sel  = seg_hi ? cal.hi_base : cal.lo_base;
  assign n_deg     = prod + $signed({{(PROD_BITS-BASE_BITS){base_sel[BASE_BITS-1]}}, base_sel});
  assign n_abs     = n_deg[PROD_BITS-1] ? PROD_BITS'(-n_deg) : PROD_BITS'(n_deg);
  assign bot_sel   = seg_hi ? cal.hi_bot : cal.lo_bot;

  assign div_ge = (rem >= dvs);

  always_comb begin
    if (ang_neg) begin
      angle_calc = (quo > Q_NEG_LIM) ? ANGLE_MIN : ANGLE_BITS'(-quo);
    end else begin
      angle_calc = (quo > Q_POS_LIM) ? ANGLE_MAX : quo[ANGLE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = no_move ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = (div_kind == DK_RAMP) ? ST_SETUP : ST_ANGLE;
        end
      end
      ST_SETUP: state_next = ST_STEP;
      ST_STEP:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ABS;
      ST_ABS:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_ANGLE: state_next = ST_OUT;
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = step_last ? ST_IDLE : ST_STEP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) begin
        cur_pulse[j] <= center_f(JOINT_BITS'(j));
      end
      step_counter <= '0;
      div_cnt      <= '0;
      div_kind     <= DK_RAMP;
    end else begin
      case (state)
        ST_CHECK: begin
          if (!no_move) begin
            div_cnt  <= DIV_LAST;
            div_kind <= DK_RAMP;
          end
        end
        ST_DIV: begin
          if (div_cnt != '0) begin
            div_cnt <= div_cnt - CNT_BITS'(1);
          end
        end
        ST_SETUP: step_counter <= '0;
        ST_STEP:  step_counter <= step_counter + STEP_BITS'(1);
        ST_LOAD: begin
          div_cnt  <= DIV_LAST;
          div_kind <= DK_ANGLE;
        end
        ST_OUT: begin
          // move finished: the target becomes the stored position
          if (m_tready && step_last) begin
            cur_pulse[joint_q[JIDX_BITS-1:0]] <= target_q;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          joint_q  <= s_tdata[3:0];
          target_q <= s_tdata[15:4];
          steps_q  <= steps_sat;
        end
      end
      ST_CHECK: begin
        // slope: |target - start| / steps on the shared divider
        rem      <= DIV_BITS'(diff_mag);
        dvs      <= DIV_BITS'(steps_q) << (QUO_BITS - 1);
        diff_neg <= diff[DIFF_BITS-1];
        pos      <= start_pulse;
      end
      ST_DIV: begin
        rem <= div_ge ? (rem - dvs) : rem;
        dvs <= dvs >> 1;
        quo <= {quo[QUO_BITS-2:0], div_ge};
      end
      ST_SETUP: begin
        dq  <= dq_calc;
        dr  <= dr_calc;
        acc <= '0;
      end
      ST_STEP: begin
        acc <= acc_new;
        pos <= pos_sum[PULSE_BITS-1:0];
      end
      ST_MUL: begin
        prod   <= prod_calc;
        seg_hi <= !d_cal[DIFF_BITS-1];
      end
      ST_ABS: begin
        mag     <= n_abs[MAG_BITS-1:0];
        ang_neg <= n_deg[PROD_BITS-1];
      end
      ST_SCALE: begin
        scaled <= SCALE_BITS'(mag) * SCALE_BITS'(RAD_K);
      end
      ST_LOAD: begin
        // rounded quotient: (2 * scaled + bot) / (2 * bot)
        rem <= {1'b0, scaled, 1'b0} + DIV_BITS'(bot_sel);
        dvs <= DIV_BITS'({bot_sel, 1'b0}) << (QUO_BITS - 1);
      end
      ST_ANGLE: out_angle <= angle_calc;
      default: ;
    endcase
  end

  assign m_tdata = {1'b0, out_angle, pos, step_counter, joint_q};
  assign m_tlast = step_last;

  // ---------------------------------------------------------------- checks
  `SRAWM_ASSERT_IMP(a_ready_not_busy, clk, rst, s_tready, !m_tvalid)
  `SRAWM_ASSERT_IMP(a_last_step, clk, rst, m_tvalid && m_tlast, step_counter == steps_q)
  `SRAWM_ASSERT_IMP(a_step_range, clk, rst, m_tvalid,
                    (step_counter != '0) && (step_counter <= steps_q))
  `SRAWM_ASSERT_IMP(a_acc_below_steps, clk, rst, m_tvalid, acc < steps_q)
  `SRAWM_ASSERT_NXT(a_idle_after_last, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

`default_nettype wire

@@ test/servo_ramp_with_angle_map_top_tb.sv @@
// self-checking testbench for the servo ramp block with per-joint angle mapping
// depends on srawm_pkg and servo_ramp_with_angle_map_top; reads no files
`default_nettype none

module servo_ramp_with_angle_map_top_tb;
  import srawm_pkg::*;

  // one interpolated step as it leaves the block
  typedef struct {
    logic [JOINT_BITS-1:0]        joint;
    logic [STEP_BITS-1:0]         step;
    logic [PULSE_BITS-1:0]        pulse;
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         last;
  } ramp_step_t;

  // keeps its own joint positions and calibration, queues the steps each move should give
  class ramp_scoreboard;
    int cal_centre[16] = '{1700, 1269, 1625, 1545, 1710, 2000, 2300, 760,
                           1290, 1720, 1570, 1520, 1940, 2010, 1240, 2200};
    int cal_base[16]   = '{-90, -90, 0, 90, 0, -90, -90, 0, -90, -90, 0, 90, 0, -90, -90, 0};
    int cal_lo_num[16] = '{-120, -30, -85, -90, -90, 105, 110, 20,
                           -60, -120, 60, 90, 129, -105, -5, -192};
    int cal_lo_den[16] = '{1110, 319, 945, 965, 310, 330, 840, 235,
                           330, 1155, 920, 940, 430, 340, 70, 1640};
    int cal_hi_num[16] = '{-60, -120, -60, -90, -129, 105, 5, 192,
                           -120, -30, 85, 90, 90, -105, -110, -20};
    // joint ten upper segment: 625 pulses for 85 degrees, as calibrated
    int cal_hi_den[16] = '{410, 1131, 625, 805, 400, 350, 100, 1690,
                           1090, 295, 625, 910, 315, 340, 775, 250};

    logic [PULSE_BITS-1:0] joint_pos[16];
    ramp_step_t            pending_steps[$];
    int                    errors;

    function new();
      for (int j = 0; j < 16; j++) joint_pos[j] = PULSE_BITS'(cal_centre[j]);
      errors = 0;
    endfunction

    function longint floor_div(longint x, longint d);
      if (x >= 0) return x / d;
      return -((-x + d - 1) / d);
    endfunction

    // pulse -> degrees on the joint's segment -> Q3.12 radians, round half away, saturate
    function logic signed [ANGLE_BITS-1:0] pulse_angle(int j, logic [PULSE_BITS-1:0] p);
      longint d, num, den, n, mag, top, bot, q;
      d = longint'(p) - cal_centre[j];
      num = (d < 0) ? cal_lo_num[j] : cal_hi_num[j];
      den = (d < 0) ? cal_lo_den[j] : cal_hi_den[j];
      n = cal_base[j] * den + d * num;
      mag = (n < 0) ? -n : n;
      top = mag * 64'd314159265 * 16;
      bot = 180 * den * 390625;
      q = (2 * top + bot) / (2 * bot);
      if (n < 0) return (q > 32768) ? ANGLE_MIN : ANGLE_BITS'(-q);
      return (q > 32767) ? ANGLE_MAX : ANGLE_BITS'(q);
    endfunction

    // returns the number of steps the move produces
    function int note_request(logic [JOINT_BITS-1:0] j, logic [PULSE_BITS-1:0] tgt,
                              logic [STEP_BITS-1:0] n_in);
      int n;
      longint start, diff;
      ramp_step_t s;
      n = (n_in > MAX_STEPS_DEF) ? MAX_STEPS_DEF : int'(n_in);
      if (n == 0 || tgt == joint_pos[j]) return 0;
      start = joint_pos[j];
      diff = longint'(tgt) - start;
      for (int i = 1; i <= n; i++) begin
        s.joint = j;
        s.step  = STEP_BITS'(i);
        s.pulse = PULSE_BITS'(start + floor_div(diff * i, n));
        s.angle = pulse_angle(j, s.pulse);
        s.last  = (i == n);
        pending_steps.push_back(s);
      end
      joint_pos[j] = tgt;
      return n;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_step(logic [OUT_TDATA_BITS-1:0] d, logic tl);
      ramp_step_t want;
      ramp_step_t got;
      got.joint = d[3:0];
      got.step  = d[10:4];
      got.pulse = d[22:11];
      got.angle = d[38:23];
      got.last  = tl;
      if (pending_steps.size() == 0) begin
        $error("result transfer with no step expected: tdata %h", d);
        errors++;
        return;
      end
      want = pending_steps.pop_front();
      compare_field("joint_out", want.joint, got.joint);
      compare_field("step_index", want.step, got.step);
      compare_field("pulse", want.pulse, got.pulse);
      compare_field("angle", want.angle, got.angle);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;   // joint[3:0], target_pulse[15:4], steps[22:16], pad
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;   // joint_out[3:0], step_index[10:4], pulse[22:11],
                                        // angle[38:23], pad
  logic                      m_tlast;

  // idle percentages of the request sender and the result receiver, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  ramp_scoreboard sb;

  servo_ramp_with_angle_map_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous ceiling: several times the slowest run with all moves at full length
  initial begin
    #60000000;
    $display("servo_ramp_with_angle_map_top test failed");
    $finish;
  end

  // receiver: tready decided at the falling edge, random stalls per phase
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // every result transfer is checked against the oldest queued step
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_step(m_tdata, m_tlast);
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_request(input logic [JOINT_BITS-1:0] j,
                              input logic [PULSE_BITS-1:0] tgt,
                              input logic [STEP_BITS-1:0] n, output int produced);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, n, tgt, j};
    do @(posedge clk); while (!s_tready);
    produced = sb.note_request(j, tgt, n);
    @(negedge clk);
  endtask

  // hold requests back until every queued step has come out
  task automatic drain_moves();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_steps.size() != 0);
  endtask

  // mostly short moves to random or nearby targets, a few long or clipped ones,
  // and some requests with no motion as noise
  task automatic random_request(output int produced);
    logic [JOINT_BITS-1:0] j;
    logic [PULSE_BITS-1:0] tgt;
    logic [STEP_BITS-1:0]  n;
    int r;
    j = JOINT_BITS'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 72)      n = STEP_BITS'($urandom_range(1, 8));
    else if (r < 87) n = STEP_BITS'($urandom_range(9, 63));
    else if (r < 91) n = STEP_BITS'($urandom_range(64, 127));
    else             n = '0;
    r = $urandom_range(0, 99);
    if (r < 75)      tgt = PULSE_BITS'($urandom_range(0, 4095));
    else if (r < 93) tgt = sb.joint_pos[j] + PULSE_BITS'($urandom_range(0, 40)) - 12'd20;
    else             tgt = sb.joint_pos[j];
    send_request(j, tgt, n, produced);
  endtask

  initial begin
    // directed moves: no motion, saturating angles, both segments of joint ten,
    // clipped step counts, tiny ramps that floor up and down, field extremes
    logic [JOINT_BITS-1:0] dir_joint[20] = '{0, 1, 4, 4, 10, 10, 10, 7, 15, 2,
                                             3, 9, 8, 8, 13, 5, 6, 11, 12, 14};
    logic [PULSE_BITS-1:0] dir_target[20] = '{1700, 3000, 4095, 0, 2500, 1000, 1570, 4095,
                                              0, 4095, 1, 2048, 1291, 1290, 12'hAAA,
                                              12'h555, 0, 2047, 1941, 1239};
    logic [STEP_BITS-1:0]  dir_steps[20] = '{5, 0, 3, 4, 6, 2, 5, 127, 64, 1,
                                             65, 100, 7, 7, 42, 21, 9, 3, 5, 2};
    int produced;
    int moving;

    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 11;
    recv_idle_pct = 75;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < 20; k++) send_request(dir_joint[k], dir_target[k], dir_steps[k], produced);

    // three idling phases: slow receiver, slow sender, then flat out
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 11 : 0;
      moving = 0;
      while (moving < 87) begin
        random_request(produced);
        if (produced > 0) moving++;
        if (moving == 44 && produced > 0) drain_moves();
      end
    end

    drain_moves();
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("servo_ramp_with_angle_map_top test passed");
    end else begin
      $display("servo_ramp_with_angle_map_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/srawm_pkg.sv
sv/servo_ramp_with_angle_map_top.sv
test/servo_ramp_with_angle_map_top_tb.sv
